>>> rtl/core/uart_commanded_pwm_dimmer_defines.svh
// ============================================================================
// UART commanded PWM dimmer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ============================================================================
`ifndef UART_COMMANDED_PWM_DIMMER_DEFINES_SVH
`define UART_COMMANDED_PWM_DIMMER_DEFINES_SVH

`ifndef SYNTHESIS

`define UCPD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define UCPD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define UCPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define UCPD_ASSERT_ALWAYS(lbl, cond, msg)

`define UCPD_ASSERT_IMPLY(lbl, ante, cons, msg)

`define UCPD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/core/ucpd_pkg.sv
// ============================================================================
// UART commanded PWM dimmer package
// Shared types, register indexes and constants of the dimmer.
// ============================================================================
package ucpd_pkg;

    localparam int DATA_BITS_DEFAULT   = 8;
    localparam int COUNT_WIDTH_DEFAULT = 16;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int PERIOD_WIDTH    = 16;
    localparam int STEP_WIDTH      = 13;
    localparam int DUTY_OUT_WIDTH  = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PWM_PERIOD = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LEVEL_STEP = 2'd1;

    localparam logic [PERIOD_WIDTH-1:0] PWM_PERIOD_RESET = 16'd4000;
    localparam logic [STEP_WIDTH-1:0]   LEVEL_STEP_RESET = 13'd400;
    localparam int                      DUTY_RESET       = 1500;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    // One classified receiver event per accepted tick.
    typedef struct packed {
        logic       frame_error;
        logic       byte_valid;
        logic [7:0] byte_value;
        logic       is_digit;
        logic [3:0] digit;
    } ucpd_event_t;

endpackage

>>> rtl/core/uart_commanded_pwm_dimmer.sv
// ============================================================================
// UART commanded PWM dimmer
// Serial digit commands set the duty of a PWM LED drive, one tick per transfer.
// ============================================================================
// Each input transfer is one base clock tick carrying baud_strobe and rx_line.
// Each tick yields exactly one result transfer with pwm_out, the echoed byte
// (byte_valid, byte_value), frame_error and the current duty_level.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// pwm_period at index 0 and level_step at index 1; other indexes are ignored.
// cfg_ready is always high; write only while no ticks are in flight.
// Throughput is one tick per cycle while in_ready is high. Each input transfer
// is classified by the receiver front end, stored in the event queue and then
// held in the PWM back end's result register.
// A two-entry queue and the result register absorb a stalled output; once
// both are full, in_ready drops until out_ready returns.
// Reset puts the receiver in idle, the duty at 1500 ticks, the counter at zero,
// the period at 4000 and the step at 400 ticks.
// ============================================================================
module uart_commanded_pwm_dimmer #(
    parameter int DATA_BITS   = ucpd_pkg::DATA_BITS_DEFAULT,
    parameter int COUNT_WIDTH = ucpd_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 baud_strobe,
    input  logic                                 rx_line,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 pwm_out,
    output logic                                 byte_valid,
    output logic [7:0]                           byte_value,
    output logic                                 frame_error,
    output logic [ucpd_pkg::DUTY_OUT_WIDTH-1:0]  duty_level,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ucpd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [ucpd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import ucpd_pkg::*;

    logic [PERIOD_WIDTH-1:0] pwm_period_reg;
    logic [STEP_WIDTH-1:0]   level_step_reg;
    logic                    push_valid;
    logic                    push_ready;
    ucpd_event_t             push_data;
    logic                    pop_valid;
    logic                    pop_ready;
    ucpd_event_t             pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_period_reg <= PWM_PERIOD_RESET;
            level_step_reg <= LEVEL_STEP_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PWM_PERIOD: pwm_period_reg <= cfg_data[PERIOD_WIDTH-1:0];
                REG_LEVEL_STEP: level_step_reg <= cfg_data[STEP_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    ucpd_rx_front #(
        .DATA_BITS (DATA_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .baud_strobe (baud_strobe),
        .rx_line     (rx_line),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    ucpd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ucpd_pwm_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pwm_period  (pwm_period_reg),
        .level_step  (level_step_reg),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pwm_out     (pwm_out),
        .byte_valid  (byte_valid),
        .byte_value  (byte_value),
        .frame_error (frame_error),
        .duty_level  (duty_level)
    );

endmodule

>>> rtl/core/ucpd_rx_front.sv
// ============================================================================
// UCPD receiver front end
// Samples the serial line on strobe ticks and classifies each tick.
// ============================================================================
module ucpd_rx_front #(
    parameter int DATA_BITS = ucpd_pkg::DATA_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  baud_strobe,
    input  logic                  rx_line,
    output logic                  push_valid,
    input  logic                  push_ready,
    output ucpd_pkg::ucpd_event_t push_data
);
    import ucpd_pkg::*;

    localparam int CNT_W = $clog2(DATA_BITS + 1);

    typedef enum logic [1:0] {RX_IDLE, RX_DATA, RX_STOP} rx_state_t;

    rx_state_t            state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [DATA_BITS-1:0] shift_reg, shift_next;
    ucpd_event_t          ev;
    logic [15:0]          value_wide;
    logic                 accept;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign push_data  = ev;
    assign accept     = in_valid && push_ready;
    assign value_wide = 16'(shift_reg);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        shift_next = shift_reg;
        ev         = '0;
        if (baud_strobe)
        begin
            unique case (state_reg)
                RX_DATA:
                begin
                    // LSB first: after all shifts the first bit sits at bit 0.
                    shift_next = {rx_line, shift_reg[DATA_BITS-1:1]};
                    count_next = count_reg + 1'b1;
                    if (count_next == CNT_W'(DATA_BITS))
                    begin
                        state_next = RX_STOP;
                    end
                end
                RX_STOP:
                begin
                    state_next = RX_IDLE;
                    if (rx_line)
                    begin
                        ev.byte_valid = 1'b1;
                        ev.byte_value = 8'(shift_reg);
                        ev.is_digit   = (value_wide >= 16'(ASCII_ZERO))
                                        && (value_wide <= 16'(ASCII_NINE));
                        ev.digit      = 4'(value_wide - 16'(ASCII_ZERO));
                    end
                    else
                    begin
                        ev.frame_error = 1'b1;
                    end
                end
                default:
                begin
                    if (!rx_line)
                    begin
                        state_next = RX_DATA;
                        count_next = '0;
                        shift_next = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RX_IDLE;
            count_reg <= '0;
            shift_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            shift_reg <= shift_next;
        end
    end

endmodule

>>> rtl/core/ucpd_queue.sv
// ============================================================================
// UCPD event queue
// Two-entry queue that decouples the receiver front end from the PWM back end.
// ============================================================================
`include "uart_commanded_pwm_dimmer_defines.svh"

module ucpd_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  ucpd_pkg::ucpd_event_t push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output ucpd_pkg::ucpd_event_t pop_data
);
    import ucpd_pkg::*;

    ucpd_event_t entry_reg [2];
    logic [1:0]  count_reg;
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic        push;
    logic        pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    `UCPD_ASSERT_ALWAYS(a_q_count_range, count_reg != 2'd3, "queue count out of range")
    `UCPD_ASSERT_NEXT(a_q_fill, push && !pop, count_reg == $past(count_reg) + 2'd1, "queue fill lost")
    `UCPD_ASSERT_IMPLY(a_q_ptrs, count_reg == 2'd0 || count_reg == 2'd2, wr_ptr_reg == rd_ptr_reg, "queue pointers disagree with count")

endmodule

>>> rtl/core/ucpd_pwm_back.sv
// ============================================================================
// UCPD PWM back end
// Applies duty commands, runs the period counter and holds the result.
// ============================================================================
`include "uart_commanded_pwm_dimmer_defines.svh"

module ucpd_pwm_back #(
    parameter int COUNT_WIDTH = ucpd_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [ucpd_pkg::PERIOD_WIDTH-1:0]    pwm_period,
    input  logic [ucpd_pkg::STEP_WIDTH-1:0]      level_step,
    input  logic                                 pop_valid,
    output logic                                 pop_ready,
    input  ucpd_pkg::ucpd_event_t                pop_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 pwm_out,
    output logic                                 byte_valid,
    output logic [7:0]                           byte_value,
    output logic                                 frame_error,
    output logic [ucpd_pkg::DUTY_OUT_WIDTH-1:0]  duty_level
);
    import ucpd_pkg::*;

    localparam int WIDE_W = ((COUNT_WIDTH > PERIOD_WIDTH) ? COUNT_WIDTH : PERIOD_WIDTH) + 1;
    localparam int PROD_W = PERIOD_WIDTH + 1;

    logic [COUNT_WIDTH-1:0]    duty_reg, duty_next;
    logic [COUNT_WIDTH-1:0]    count_reg, count_next;
    logic [PROD_W-1:0]         product;
    logic [PERIOD_WIDTH-1:0]   clipped;
    logic [WIDE_W-1:0]         count_inc;
    logic                      out_valid_reg;
    logic                      pwm_reg;
    logic                      byte_valid_reg;
    logic [7:0]                byte_value_reg;
    logic                      frame_error_reg;
    logic [DUTY_OUT_WIDTH-1:0] duty_level_reg;
    logic                      pop;

    assign pop_ready = !out_valid_reg || out_ready;
    assign pop       = pop_valid && pop_ready;

    assign out_valid   = out_valid_reg;
    assign pwm_out     = pwm_reg;
    assign byte_valid  = byte_valid_reg;
    assign byte_value  = byte_value_reg;
    assign frame_error = frame_error_reg;
    assign duty_level  = duty_level_reg;

    always_comb
    begin
        product = PROD_W'(pop_data.digit) * PROD_W'(level_step);
        if (product > PROD_W'(pwm_period))
        begin
            clipped = pwm_period;
        end
        else
        begin
            clipped = product[PERIOD_WIDTH-1:0];
        end

        duty_next = duty_reg;
        if (pop_data.byte_valid && pop_data.is_digit)
        begin
            duty_next = COUNT_WIDTH'(clipped);
        end

        // A period of zero behaves as one: the counter stays at zero.
        count_inc = WIDE_W'(count_reg) + WIDE_W'(1);
        if (count_inc >= WIDE_W'(pwm_period))
        begin
            count_next = '0;
        end
        else
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pwm_reg         <= (count_reg < duty_reg);
            byte_valid_reg  <= pop_data.byte_valid;
            byte_value_reg  <= pop_data.byte_value;
            frame_error_reg <= pop_data.frame_error;
            duty_level_reg  <= DUTY_OUT_WIDTH'(duty_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            duty_reg      <= COUNT_WIDTH'(DUTY_RESET);
            count_reg     <= '0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                duty_reg      <= duty_next;
                count_reg     <= count_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `UCPD_ASSERT_IMPLY(a_bk_one_event, out_valid_reg, !(byte_valid_reg && frame_error_reg), "echo and frame error together")
    `UCPD_ASSERT_NEXT(a_bk_duty_hold, !pop, duty_reg == $past(duty_reg), "duty moved without a transfer")
    `UCPD_ASSERT_NEXT(a_bk_fill, pop, out_valid_reg, "result register not loaded")

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// UART commanded PWM dimmer testbench
// Serial frames with random baud timing and line noise are sent one tick per
// transfer. A tick-accurate model of the receiver, duty update and PWM counter
// predicts every result, and each result transfer is checked against it.
// Several period and step settings are used, down to zero and up to full scale.
// ============================================================================
module tb_top;
    import ucpd_pkg::*;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_3 = 2'd3;
    localparam int SETTLE_CYCLES = 6;

    typedef enum logic [1:0] {
        RX_IDLE,
        RX_DATA,
        RX_STOP
    } rx_state_t;

    typedef struct {
        logic        pwm;
        logic        valid;
        logic [7:0]  value;
        logic        ferr;
        logic [15:0] duty;
    } tick_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       baud_strobe = 1'b0;
    logic                       rx_line = 1'b1;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic                       pwm_out;
    logic                       byte_valid;
    logic [7:0]                 byte_value;
    logic                       frame_error;
    logic [DUTY_OUT_WIDTH-1:0]  duty_level;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

    // Model of the dimmer state and its registers.
    rx_state_t   rx_state;
    logic [3:0]  rx_bits;
    logic [7:0]  rx_shift;
    logic [15:0] duty_model;
    logic [15:0] count_model;
    logic [15:0] period_reg;
    logic [12:0] step_reg;

    tick_result_t pending_results[$];
    int           fail_count = 0;
    int           ticks_sent = 0;
    bit           steady_flow = 1'b0;

    uart_commanded_pwm_dimmer uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .baud_strobe (baud_strobe),
        .rx_line     (rx_line),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pwm_out     (pwm_out),
        .byte_valid  (byte_valid),
        .byte_value  (byte_value),
        .frame_error (frame_error),
        .duty_level  (duty_level),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        out_ready <= steady_flow || ($urandom_range(99) >= 36);
    end

    // Work out the result of one accepted tick and advance the model.
    function automatic void predict_tick(input logic strobe, input logic line);
        tick_result_t r;
        logic [31:0]  level;
        logic [16:0]  next_count;
        r.pwm   = (count_model < duty_model);
        r.valid = 1'b0;
        r.value = 8'd0;
        r.ferr  = 1'b0;
        if (strobe)
        begin
            case (rx_state)
                RX_DATA:
                begin
                    if (line)
                        rx_shift[rx_bits[2:0]] = 1'b1;
                    rx_bits = rx_bits + 4'd1;
                    if (rx_bits >= 4'd8)
                        rx_state = RX_STOP;
                end
                RX_STOP:
                begin
                    if (line)
                    begin
                        r.valid = 1'b1;
                        r.value = rx_shift;
                        if (rx_shift >= ASCII_ZERO && rx_shift <= ASCII_NINE)
                        begin
                            level = rx_shift[3:0] * step_reg;
                            if (level > period_reg)
                                level = period_reg;
                            duty_model = level[15:0];
                        end
                    end
                    else
                    begin
                        r.ferr = 1'b1;
                    end
                    rx_state = RX_IDLE;
                end
                default:
                begin
                    rx_state = RX_IDLE;
                    if (!line)
                    begin
                        rx_bits  = 4'd0;
                        rx_shift = 8'd0;
                        rx_state = RX_DATA;
                    end
                end
            endcase
        end
        next_count = {1'b0, count_model} + 17'd1;
        if (next_count >= {1'b0, period_reg})
            count_model = 16'd0;
        else
            count_model = next_count[15:0];
        r.duty = duty_model;
        pending_results.push_back(r);
    endfunction

    always @(posedge clk)
    begin : check_results
        tick_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: result transfer with nothing expected", $realtime);
            end
            else
            begin
                want = pending_results.pop_front();
                if (pwm_out !== want.pwm || byte_valid !== want.valid
                    || byte_value !== want.value || frame_error !== want.ferr
                    || duty_level !== want.duty)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: expected pwm %b valid %b byte %h ferr %b duty %0d,",
                                 $realtime, want.pwm, want.valid, want.value, want.ferr,
                                 want.duty,
                                 " got pwm %b valid %b byte %h ferr %b duty %0d",
                                 pwm_out, byte_valid, byte_value, frame_error,
                                 duty_level);
                end
            end
        end
    end

    // Send one tick, with random idle cycles ahead of it unless traffic is steady.
    task automatic send_tick(input logic strobe, input logic line);
        while (!steady_flow && $urandom_range(99) < 36)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        baud_strobe <= strobe;
        rx_line     <= line;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_tick(strobe, line);
        ticks_sent++;
    endtask

    // Non-sample ticks between bit sample points, with a random line level.
    task automatic send_gap(input int max_gap);
        repeat ($urandom_range(max_gap))
            send_tick(1'b0, 1'($urandom_range(1)));
    endtask

    task automatic send_frame(input logic [7:0] data, input logic stop_bit, input int max_gap);
        send_gap(max_gap);
        send_tick(1'b1, 1'b0);
        for (int i = 0; i < 8; i++)
        begin
            send_gap(max_gap);
            send_tick(1'b1, data[i]);
        end
        send_gap(max_gap);
        send_tick(1'b1, stop_bit);
    endtask

    // Registers are written only after every pending result has come back.
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PWM_PERIOD: period_reg = data;
            REG_LEVEL_STEP: step_reg = data[12:0];
            default: ;
        endcase
    endtask

    task automatic set_dimmer(input logic [15:0] period, input logic [15:0] step);
        write_reg(REG_PWM_PERIOD, period);
        write_reg(REG_LEVEL_STEP, step);
    endtask

    task automatic test_reset_state();
        // Without a strobe the receiver must ignore a low line.
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
    endtask

    task automatic test_directed_frames();
        send_frame(ASCII_NINE, 1'b1, 0);
        send_frame(8'hFF, 1'b0, 0);
        send_frame(ASCII_ZERO, 1'b1, 0);
    endtask

    task automatic test_register_extremes();
        // A step written with all ones keeps its low 13 bits; a zero period acts as one.
        set_dimmer(16'd0, 16'hFFFF);
        send_frame(ASCII_NINE, 1'b1, 0);
        set_dimmer(16'hFFFF, 16'd7281);
        send_frame(ASCII_NINE, 1'b1, 1);
        write_reg(REG_SPARE_2, 16'hFFFF);
        write_reg(REG_SPARE_3, 16'h0000);
        send_frame(8'h3A, 1'b1, 0);
    endtask

    task automatic run_traffic(input int count);
        int          target;
        int          pick;
        logic [7:0]  data;
        target = ticks_sent + count;
        while (ticks_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                if ($urandom_range(99) < 60)
                    data = ASCII_ZERO + 8'($urandom_range(9));
                else
                    data = 8'($urandom_range(255));
                send_frame(data, $urandom_range(99) < 88, $urandom_range(3));
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(1, 4))
                    send_tick(1'($urandom_range(1)), 1'b1);
            end
            else
            begin
                // Line noise on sample points, then enough high samples to resync.
                repeat ($urandom_range(1, 6))
                    send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
                repeat (10)
                    send_tick(1'b1, 1'b1);
            end
        end
    endtask

    task automatic test_random_traffic();
        set_dimmer(PWM_PERIOD_RESET, 16'(LEVEL_STEP_RESET));
        run_traffic(145);
        set_dimmer(16'hFFFF, 16'd7281);
        run_traffic(145);
        set_dimmer(16'd300, 16'd400);
        run_traffic(145);
        steady_flow = 1'b1;
        set_dimmer(16'd37, 16'd5);
        run_traffic(145);
        steady_flow = 1'b0;
        set_dimmer(16'd1, 16'hFFFF);
        run_traffic(145);
        set_dimmer(16'd0, 16'd0);
        run_traffic(145);
        write_reg(REG_SPARE_2, 16'($urandom));
        write_reg(REG_SPARE_3, 16'($urandom));
        set_dimmer(16'($urandom_range(2, 600)), 16'($urandom_range(8191)));
        run_traffic(145);
    endtask

    task automatic finish_run();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (pending_results.size() != 0 && waited < 10000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    endtask

    initial
    begin
        rx_state    = RX_IDLE;
        rx_bits     = 4'd0;
        rx_shift    = 8'd0;
        duty_model  = 16'(DUTY_RESET);
        count_model = 16'd0;
        period_reg  = PWM_PERIOD_RESET;
        step_reg    = LEVEL_STEP_RESET;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_directed_frames();
        test_register_extremes();
        test_random_traffic();
        finish_run();
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/ucpd_pkg.sv
rtl/core/ucpd_rx_front.sv
rtl/core/ucpd_queue.sv
rtl/core/ucpd_pwm_back.sv
rtl/core/uart_commanded_pwm_dimmer.sv
sim/tb_top.sv
